// ===== src/glitch_loop_buffer_fade_assert.svh =====
// Assertion macros shared by the loop buffer RTL.
`ifndef GLITCH_LOOP_BUFFER_FADE_ASSERT_SVH
`define GLITCH_LOOP_BUFFER_FADE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define GLBF_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define GLBF_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/glbf_pkg.sv =====
// Shared types and fixed field widths of the glitch loop buffer.
package glbf_pkg;

   localparam int LEN_W    = 13;
   localparam int SAMPLE_W = 16;

   typedef logic        [LEN_W-1:0]    len_type;
   typedef logic signed [SAMPLE_W-1:0] sample_type;

endpackage

// ===== src/glbf_req_if.sv =====
// Request channel of the loop buffer: loop length, direction and recorded sample.
interface glbf_req_if import glbf_pkg::*; ();
   logic       valid;
   logic       ready;
   len_type    loop_len;
   logic       reverse_play;
   sample_type rec_sample;

   modport source (output valid, output loop_len, output reverse_play, output rec_sample,
                   input ready);
   modport sink   (input valid, input loop_len, input reverse_play, input rec_sample,
                   output ready);
endinterface

// ===== src/glbf_rsp_if.sv =====
// Response channel of the loop buffer: played sample and wrap flag.
interface glbf_rsp_if import glbf_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type play_sample;
   logic       loop_wrapped;

   modport source (output valid, output play_sample, output loop_wrapped, input ready);
   modport sink   (input valid, input play_sample, input loop_wrapped, output ready);
endinterface

// ===== src/glitch_loop_buffer_fade.sv =====
// Glitch loop buffer with linear fades, one shared fade multiply/divide unit.
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+-----------------------------------------
//   req_ch  | in  | valid/ready         | loop_len, reverse_play, rec_sample
//   rsp_ch  | out | valid/ready         | play_sample, loop_wrapped
//
// Each item steps through read, load and select, then a multiply and a divide pass for each fade
//   applied (at most three), then write, then a clear of every memory entry past a shortened
//   loop (MEM_DEPTH - loop length entries), then modulo steps that subtract the loop length
//   until the position lies below it, then done; a new item is taken only in idle.
// A fade is two passes through one multiplier: the gain, then the reciprocal of FADE_LEN.
// The memory has one read port and one write port, never both used in the same cycle.
// Reset clears the sequencer, position, previous length, fade flag and output valid; the
//   memory is not cleared and holds nothing defined until written.
// The next item is taken while a result waits in the output register; a stalled result
//   holds the sequencer in its final state.
`include "glitch_loop_buffer_fade_assert.svh"

module glitch_loop_buffer_fade import glbf_pkg::*; #(
   parameter int MEM_DEPTH = 4096,
   parameter int FADE_LEN  = 64
) (
   input logic        clock,
   input logic        reset,
   glbf_req_if.sink   req_ch,
   glbf_rsp_if.source rsp_ch
);

   localparam int AW  = $clog2(MEM_DEPTH);
   localparam int MW  = AW + 1;
   localparam int LW  = ($clog2(MEM_DEPTH + 1) < LEN_W) ? $clog2(MEM_DEPTH + 1) : LEN_W;
   localparam int KW  = $clog2(FADE_LEN + 1);
   localparam int QW  = SAMPLE_W + KW;
   localparam int M1  = (AW > LEN_W) ? AW : LEN_W;
   localparam int M2  = (M1 > KW) ? M1 : KW;
   localparam int SW  = M2 + 2;
   localparam int FL  = $clog2(FADE_LEN);
   localparam int RS  = QW + FL;
   localparam int MBW = QW + 2;
   localparam int PW  = QW + MBW;
   localparam longint RCP = ((longint'(1) << RS) + longint'(FADE_LEN) - 1) / longint'(FADE_LEN);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b00_0000_0001,
      S_READ  = 10'b00_0000_0010,
      S_LOAD  = 10'b00_0000_0100,
      S_SEL   = 10'b00_0000_1000,
      S_MUL   = 10'b00_0001_0000,
      S_DIV   = 10'b00_0010_0000,
      S_WRITE = 10'b00_0100_0000,
      S_CLEAR = 10'b00_1000_0000,
      S_MOD   = 10'b01_0000_0000,
      S_DONE  = 10'b10_0000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [AW-1:0]     pos_ff, pos_in;
   logic [LW-1:0]     prev_ff, prev_in;
   logic              fip_ff, fip_in;
   logic [LW-1:0]     len_ff, len_in;
   logic              rev_ff, rev_in;
   sample_type        v_ff, v_in;
   sample_type        wv_ff, wv_in;
   logic              pend_ab_ff, pend_ab_in;
   logic              pend_c_ff, pend_c_in;
   logic              pend_w_ff, pend_w_in;
   logic              tgt_w_ff, tgt_w_in;
   logic              neg_ff, neg_in;
   logic [SAMPLE_W-1:0] mag_ff, mag_in;
   logic [KW-1:0]     kk_ff, kk_in;
   logic [QW-1:0]     quo_ff, quo_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [MW-1:0]     mod_ff, mod_in;
   logic              wrap_ff, wrap_in;
   logic              rsp_valid_ff, rsp_valid_in;
   sample_type        play_ff, play_in;
   logic              wrap_out_ff, wrap_out_in;

   sample_type        loop_mem_ff [MEM_DEPTH];
   sample_type        rd_data_ff;
   logic              mem_re, mem_we;
   logic [AW-1:0]     mem_raddr, mem_waddr;
   sample_type        mem_wdata;

   logic signed [SW-1:0] rs, ps, ls, fs, ka, kb, idx, k_sel, rec_len;
   logic              cond_a, cond_b, cond_c, cond_wb, fip_mid, clr_hit, req_take;
   logic [QW-1:0]     mul_a;
   logic [MBW-1:0]    mul_b;
   logic [PW-1:0]     mul_p;
   logic [SAMPLE_W-1:0] qmag;
   sample_type        fade_res, opnd;

   assign rs      = signed'(SW'(pos_ff));
   assign ps      = signed'(SW'(prev_ff));
   assign ls      = signed'(SW'(len_ff));
   assign fs      = signed'(SW'(FADE_LEN));
   assign ka      = ps - 1 - rs;
   assign kb      = ls - 1 - rs;
   assign idx     = kb;
   assign rec_len = signed'(SW'(req_ch.loop_len));

   assign cond_a  = (ls > ps) && (ka >= 0) && (ka < fs);
   assign cond_b  = !cond_a && (ls < ps) && (kb < fs);
   assign fip_mid = fip_ff || cond_a || cond_b;
   assign cond_c  = (rs <= fs) && (fip_mid || (ps != ls));
   assign cond_wb = (rs > ls - 1 - fs) && (ps > ls);
   assign clr_hit = (rs == ls - 1) && (ps > ls);

   // Shared multiplier: magnitude times gain, then the product times the reciprocal of
   // FADE_LEN; the reciprocal is rounded up so the shifted result is the exact quotient.
   assign mul_a    = (state_ff == S_DIV) ? quo_ff : QW'(mag_ff);
   assign mul_b    = (state_ff == S_DIV) ? MBW'(RCP) : MBW'(kk_ff);
   assign mul_p    = PW'(mul_a) * PW'(mul_b);
   assign qmag     = mul_p[RS +: SAMPLE_W];
   assign fade_res = neg_ff ? sample_type'(-qmag) : sample_type'(qmag);

   assign req_take = req_ch.valid && req_ch.ready;
   assign req_ch.ready = state_ff == S_IDLE;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.play_sample  = play_ff;
   assign rsp_ch.loop_wrapped = wrap_out_ff;

   // Memory port control
   always_comb begin
      mem_re    = state_ff == S_READ;
      mem_raddr = rev_ff ? idx[AW-1:0] : pos_ff;
      mem_we    = (state_ff == S_WRITE) || (state_ff == S_CLEAR);
      mem_waddr = (state_ff == S_CLEAR) ? clr_ff : pos_ff;
      mem_wdata = (state_ff == S_CLEAR) ? sample_type'(0) : wv_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         loop_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= loop_mem_ff[mem_raddr];
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      prev_in      = prev_ff;
      fip_in       = fip_ff;
      len_in       = len_ff;
      rev_in       = rev_ff;
      v_in         = v_ff;
      wv_in        = wv_ff;
      pend_ab_in   = pend_ab_ff;
      pend_c_in    = pend_c_ff;
      pend_w_in    = pend_w_ff;
      tgt_w_in     = tgt_w_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      kk_in        = kk_ff;
      quo_in       = quo_ff;
      clr_in       = clr_ff;
      mod_in       = mod_ff;
      wrap_in      = wrap_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      play_in      = play_ff;
      wrap_out_in  = wrap_out_ff;
      k_sel        = '0;
      opnd         = v_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (rec_len < 1) begin
                  len_in = LW'(1);
               end else if (rec_len > signed'(SW'(MEM_DEPTH))) begin
                  len_in = LW'(MEM_DEPTH);
               end else begin
                  len_in = LW'(req_ch.loop_len);
               end
               rev_in   = req_ch.reverse_play;
               wv_in    = req_ch.rec_sample;
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            // silence past the previous loop, or for a mirrored index below zero
            if ((rs >= ps) || (rev_ff && (idx < 0))) begin
               v_in = '0;
            end else begin
               v_in = rd_data_ff;
            end
            pend_ab_in = !rev_ff && (cond_a || cond_b);
            pend_c_in  = !rev_ff && cond_c;
            pend_w_in  = cond_a || cond_wb;
            if (!rev_ff) begin
               fip_in = (cond_c && (rs == fs)) ? 1'b0 : fip_mid;
            end
            state_in = S_SEL;
         end
         S_SEL: begin
            if (pend_ab_ff) begin
               pend_ab_in = 1'b0;
               k_sel      = cond_a ? ka : kb;
               opnd       = v_ff;
               tgt_w_in   = 1'b0;
               state_in   = S_MUL;
            end else if (pend_c_ff) begin
               pend_c_in  = 1'b0;
               k_sel      = rs;
               opnd       = v_ff;
               tgt_w_in   = 1'b0;
               state_in   = S_MUL;
            end else if (pend_w_ff) begin
               pend_w_in  = 1'b0;
               k_sel      = cond_a ? ka : kb;
               opnd       = wv_ff;
               tgt_w_in   = 1'b1;
               state_in   = S_MUL;
            end else begin
               state_in   = S_WRITE;
            end
            // clamp the gain to 0..FADE_LEN
            if (k_sel <= 0) begin
               kk_in = '0;
            end else if (k_sel >= fs) begin
               kk_in = KW'(FADE_LEN);
            end else begin
               kk_in = k_sel[KW-1:0];
            end
            neg_in = opnd[SAMPLE_W-1];
            mag_in = opnd[SAMPLE_W-1] ? SAMPLE_W'(-opnd) : SAMPLE_W'(opnd);
         end
         S_MUL: begin
            quo_in   = mul_p[QW-1:0];
            state_in = S_DIV;
         end
         S_DIV: begin
            if (tgt_w_ff) begin
               wv_in = fade_res;
            end else begin
               v_in  = fade_res;
            end
            state_in = S_SEL;
         end
         S_WRITE: begin
            mod_in  = MW'(pos_ff) + MW'(1);
            wrap_in = (rs + 1) >= ls;
            clr_in  = pos_ff + AW'(1);
            state_in = clr_hit ? S_CLEAR : S_MOD;
         end
         S_CLEAR: begin
            if (clr_ff == AW'(MEM_DEPTH - 1)) begin
               state_in = S_MOD;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         S_MOD: begin
            // reduce the advanced position below the loop length
            if (mod_ff >= MW'(len_ff)) begin
               mod_in = mod_ff - MW'(len_ff);
            end else begin
               pos_in = mod_ff[AW-1:0];
               if (wrap_ff) begin
                  prev_in = len_ff;
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               play_in      = v_ff;
               wrap_out_in  = wrap_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= '0;
         prev_ff      <= '0;
         fip_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pend_ab_ff   <= 1'b0;
         pend_c_ff    <= 1'b0;
         pend_w_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         prev_ff      <= prev_in;
         fip_ff       <= fip_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ab_ff   <= pend_ab_in;
         pend_c_ff    <= pend_c_in;
         pend_w_ff    <= pend_w_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      rev_ff      <= rev_in;
      v_ff        <= v_in;
      wv_ff       <= wv_in;
      tgt_w_ff    <= tgt_w_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      kk_ff       <= kk_in;
      quo_ff      <= quo_in;
      clr_ff      <= clr_in;
      mod_ff      <= mod_in;
      wrap_ff     <= wrap_in;
      play_ff     <= play_in;
      wrap_out_ff <= wrap_out_in;
   end

   `GLBF_ASSERT_IMP(a_pos_in_loop, state_ff == S_DONE, MW'(pos_ff) < MW'(len_ff),
                    "position not below loop length after advance")
   `GLBF_ASSERT_IMP(a_clear_past_loop, state_ff == S_CLEAR, MW'(clr_ff) >= MW'(len_ff),
                    "clear reached inside the loop")
   `GLBF_ASSERT_IMP(a_fade_no_gain, state_ff == S_DIV, qmag <= mag_ff,
                    "fade result larger than its operand")
   `GLBF_ASSERT_NXT(a_prev_len_on_wrap, state_ff != S_MOD, $stable(prev_ff),
                    "previous loop length changed outside the wrap step")

endmodule

// ===== bench/tb_glitch_loop_buffer_fade.sv =====
// Self-checking bench for the glitch loop buffer: loop lengths, reverse reads, fades and clears.
module tb_glitch_loop_buffer_fade import glbf_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MEM_DEPTH     = 4096;
   localparam int FADE_LEN      = 64;
   localparam int RANDOM_TICKS  = 124;
   localparam int HOLD_AT       = 90;
   localparam int LONG_HOLD     = 2*MEM_DEPTH + 400;
   localparam int SETTLE_CYCLES = 2*MEM_DEPTH + 200;

   // State copies: PLAN follows the stimulus as it is built, LIVE follows accepted items.
   localparam int PLAN = 0;
   localparam int LIVE = 1;
   // Handshake sides for idle patterns.
   localparam int SEND = 0;
   localparam int TAKE = 1;

   typedef struct packed {
      len_type    loop_len;
      logic       reverse_play;
      sample_type rec_sample;
      logic       wait_drain;
   } tick_type;

   typedef struct packed {
      sample_type play_sample;
      logic       loop_wrapped;
   } play_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   glbf_req_if req_ch ();
   glbf_rsp_if rsp_ch ();

   glitch_loop_buffer_fade #(.MEM_DEPTH(MEM_DEPTH), .FADE_LEN(FADE_LEN)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   logic       drv_valid = 1'b0;
   len_type    drv_len   = '0;
   logic       drv_rev   = 1'b0;
   sample_type drv_rec   = '0;
   logic       rsp_ready_q = 1'b0;

   assign req_ch.valid        = drv_valid;
   assign req_ch.loop_len     = drv_len;
   assign req_ch.reverse_play = drv_rev;
   assign req_ch.rec_sample   = drv_rec;
   assign rsp_ch.ready        = rsp_ready_q;

   tick_type tick_q[$];
   play_type pending_play_q[$];

   sample_type loop_mem_st[2][MEM_DEPTH];
   bit         written_st[2][MEM_DEPTH];
   int         pos_st[2];
   int         prev_len_st[2];
   bit         fade_pend_st[2];

   int  phase_left[2];
   bit  calm_phase[2];
   int  send_gap, take_gap;
   int  items_sent;
   int  hold_left;
   bit  hold_done;
   int  err_count, n_rev, n_wraps, n_loud, n_checked, n_clears;

   always #4 clock = ~clock;

   function automatic int eff_len(input len_type len_in);
      int l;
      l = int'(len_in);
      if (l < 1) l = 1;
      if (l > MEM_DEPTH) l = MEM_DEPTH;
      return l;
   endfunction

   // v * k / FADE_LEN, k held to 0..FADE_LEN, truncated toward zero.
   function automatic int scale_fade(input int v, input int k);
      int kk, mag;
      if (k <= 0) return 0;
      kk  = (k >= FADE_LEN) ? FADE_LEN : k;
      mag = ((v < 0) ? -v : v) * kk / FADE_LEN;
      return (v < 0) ? -mag : mag;
   endfunction

   // One audio tick on state copy c: read with fades, record, clear tail, advance.
   function automatic void step_loop(input int c, input len_type len_in, input logic rev,
                                     input sample_type rec, output sample_type play,
                                     output logic wrapped);
      int l, r, p, idx, v, wv, i;
      l = eff_len(len_in);
      r = pos_st[c];
      p = prev_len_st[c];
      wrapped = 1'b0;
      if (rev) begin
         idx = l - 1 - r;
         v = (idx < 0) ? 0 : int'(loop_mem_st[c][idx]);
      end else begin
         v = int'(loop_mem_st[c][r]);
         if (l > p && p - 1 - r >= 0 && p - 1 - r < FADE_LEN) begin
            v = scale_fade(v, p - 1 - r);
            fade_pend_st[c] = 1'b1;
         end else if (l < p && l - 1 - r < FADE_LEN) begin
            v = scale_fade(v, l - 1 - r);
            fade_pend_st[c] = 1'b1;
         end
         if (r <= FADE_LEN && (fade_pend_st[c] || p != l)) begin
            if (r == FADE_LEN) fade_pend_st[c] = 1'b0;
            v = scale_fade(v, r);
         end
      end
      if (r > p - 1) v = 0;

      wv = int'(rec);
      if (l > p && p - 1 - r >= 0 && p - 1 - r < FADE_LEN) wv = scale_fade(wv, p - 1 - r);
      if (r > l - 1 - FADE_LEN && p > l) wv = scale_fade(wv, l - 1 - r);
      loop_mem_st[c][r] = sample_type'(wv);
      written_st[c][r]  = 1'b1;
      // Silence everything past a shortened loop once its last entry is written.
      if (r == l - 1 && p > l) begin
         for (i = r + 1; i < MEM_DEPTH; i++) begin
            loop_mem_st[c][i] = '0;
            written_st[c][i]  = 1'b1;
         end
         if (c == LIVE) n_clears++;
      end

      r++;
      if (r >= l) begin
         prev_len_st[c] = l;
         r = r % l;
         wrapped = 1'b1;
      end
      pos_st[c] = r;
      play = sample_type'(v);
   endfunction

   // Queue one tick; drop reverse where it would hand back an entry never written.
   function automatic void add_tick(input int len_v, input bit rev, input sample_type rec,
                                    input bit drain);
      tick_type   t;
      int         r, idx;
      sample_type ps;
      logic       wf;
      r = pos_st[PLAN];
      if (rev && r <= prev_len_st[PLAN] - 1) begin
         idx = eff_len(len_type'(len_v)) - 1 - r;
         if (idx >= 0 && !written_st[PLAN][idx]) rev = 1'b0;
      end
      t = '{loop_len: len_type'(len_v), reverse_play: rev, rec_sample: rec, wait_drain: drain};
      step_loop(PLAN, t.loop_len, t.reverse_play, t.rec_sample, ps, wf);
      tick_q.push_back(t);
   endfunction

   // Mostly short gaps, a few long ones, with calm phases of no gaps at all.
   function automatic int pick_gap(input int side);
      int roll;
      if (phase_left[side] == 0) begin
         calm_phase[side] = ($urandom_range(0, 3) == 0);
         phase_left[side] = $urandom_range(20, 150);
      end
      phase_left[side]--;
      if (calm_phase[side]) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Driver: predict each accepted item, then offer the next one.
   always @(posedge clock) begin
      tick_type   nxt;
      sample_type ps;
      logic       wf;
      if (reset) begin
         drv_valid <= 1'b0;
         items_sent <= 0;
      end else begin
         if (drv_valid && req_ch.ready) begin
            step_loop(LIVE, drv_len, drv_rev, drv_rec, ps, wf);
            pending_play_q.push_back('{play_sample: ps, loop_wrapped: wf});
            items_sent <= items_sent + 1;
            if (drv_rev) n_rev++;
         end
         if (!drv_valid || req_ch.ready) begin
            if (tick_q.size() == 0 || (tick_q[0].wait_drain && pending_play_q.size() != 0)) begin
               drv_valid <= 1'b0;
            end else if (send_gap > 0) begin
               send_gap--;
               drv_valid <= 1'b0;
            end else begin
               nxt = tick_q.pop_front();
               drv_len   <= nxt.loop_len;
               drv_rev   <= nxt.reverse_play;
               drv_rec   <= nxt.rec_sample;
               drv_valid <= 1'b1;
               send_gap = pick_gap(SEND);
            end
         end
      end
   end

   // Long receiver hold, once, so the block backs up and stalls its input.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && items_sent >= HOLD_AT) begin
         hold_left <= LONG_HOLD;
         hold_done <= 1'b1;
      end
   end

   // Monitor: compare each result with the oldest prediction, then pace ready.
   always @(posedge clock) begin
      play_type want;
      if (reset) begin
         rsp_ready_q <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ready_q) begin
            n_checked++;
            if (rsp_ch.loop_wrapped) n_wraps++;
            if (rsp_ch.play_sample != '0) n_loud++;
            if (pending_play_q.size() == 0) begin
               $error("unexpected result: play_sample %0d loop_wrapped %0b",
                      rsp_ch.play_sample, rsp_ch.loop_wrapped);
               err_count++;
            end else begin
               want = pending_play_q.pop_front();
               if (rsp_ch.play_sample !== want.play_sample) begin
                  $error("play_sample: expected %0d, got %0d",
                         want.play_sample, rsp_ch.play_sample);
                  err_count++;
               end
               if (rsp_ch.loop_wrapped !== want.loop_wrapped) begin
                  $error("loop_wrapped: expected %0b, got %0b",
                         want.loop_wrapped, rsp_ch.loop_wrapped);
                  err_count++;
               end
            end
         end
         if (hold_left > 0) begin
            rsp_ready_q <= 1'b0;
         end else if (take_gap > 0) begin
            take_gap--;
            rsp_ready_q <= 1'b0;
         end else begin
            rsp_ready_q <= 1'b1;
            take_gap = pick_gap(TAKE);
         end
      end
   end

   initial begin
      #80_000_000;
      $display("glitch_loop_buffer_fade regression: fail");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      int  roll, seg_len, run, k, target, long_segs;
      bit  drain, drain_done;
      long_segs  = 0;
      drain_done = 1'b0;

      // Fill a six-entry loop with extremes, play it back both ways.
      add_tick(6, 0, 16'sh7FFF, 0);
      add_tick(6, 0, 16'sh8000, 0);
      add_tick(6, 0, 16'sh0000, 0);
      add_tick(6, 0, 16'shFFFF, 0);
      add_tick(6, 0, 16'sh0001, 0);
      add_tick(6, 0, 16'sh3039, 0);
      for (k = 0; k < 6; k++) add_tick(6, 1, sample_type'($urandom), 0);
      for (k = 0; k < 4; k++) add_tick(6, 0, sample_type'($urandom), 0);
      // Reverse with the position past a shortened loop: negative mirrored index.
      add_tick(2, 1, 16'sh7FFF, 0);
      // Grow by one: the old end fades to silence, then a read past the old length.
      add_tick(3, 0, 16'sh8000, 0);
      add_tick(3, 0, 16'sh7FFF, 0);
      // Zero length acts as one and clears the whole tail, last entry included.
      add_tick(0, 0, 16'shAAAA, 0);
      // Over-long length clamps to the memory depth.
      add_tick(8191, 0, 16'sh5555, 0);
      add_tick(8191, 1, 16'sh7FFF, 0);
      // Shrink below the position: forward read past a shortened loop.
      add_tick(1, 0, 16'sh8000, 0);
      add_tick(1, 0, 16'sh1234, 0);

      target = tick_q.size() + RANDOM_TICKS;
      while (tick_q.size() < target) begin
         roll = $urandom_range(0, 99);
         if (roll < 12) begin
            seg_len = $urandom_range(0, 8191);
            run = $urandom_range(1, 3);
         end else if (roll < 22 && long_segs < 2) begin
            long_segs++;
            seg_len = $urandom_range(FADE_LEN + 1, 2*FADE_LEN + 20);
            run = $urandom_range(40, 100);
         end else begin
            seg_len = $urandom_range(1, 24);
            run = $urandom_range(seg_len, 3*seg_len + 4);
         end
         for (k = 0; k < run && tick_q.size() < target; k++) begin
            drain = !drain_done && tick_q.size() >= target / 2;
            if (drain) drain_done = 1'b1;
            add_tick(seg_len, $urandom_range(0, 3) == 0, sample_type'($urandom), drain);
         end
      end

      while (tick_q.size() != 0 || drv_valid) @(posedge clock);
      while (pending_play_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d ticks (%0d reverse), %0d loop wraps, %0d tail clears",
               items_sent, n_rev, n_wraps, n_clears);
      $display("checked %0d results, %0d non-silent, %0d mismatches",
               n_checked, n_loud, err_count);
      if (err_count == 0) begin
         $display("glitch_loop_buffer_fade regression: pass");
      end else begin
         $display("glitch_loop_buffer_fade regression: fail");
      end
      $finish;
   end

endmodule
